/* design/pic_pkg.sv */
// Shared types and constants for the PWM input capture block.
// No dependencies; the interfaces and the top level take names from here.
package pic_pkg;

  // Field widths of the beats.
  localparam int unsigned ChW    = 1;
  localparam int unsigned TsW    = 32;
  localparam int unsigned TpsW   = 32;
  localparam int unsigned DutyW  = 7;

  // Default number of capture channels.
  localparam int unsigned Channels = 2;

  // Reset value of the ticks-per-second register.
  localparam logic [TpsW-1:0] TpsReset = 32'd1000000;

  // Full-scale duty in percent.
  localparam logic [DutyW-1:0] DutyFull = 7'd100;

  // Shared divider: a 40-bit dividend shift register. The frequency quotient
  // takes 32 steps, the duty quotient (on time times 100) takes 39 steps.
  localparam int unsigned DivW      = 40;
  localparam int unsigned FreqSteps = 32;
  localparam int unsigned DutySteps = 39;
  localparam int unsigned ProdW     = DutySteps;
  localparam int unsigned DivCntW   = $clog2(DutySteps);

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DIVF,
    S_LDD,
    S_DIVD,
    S_DONE
  } pic_state_e;

endpackage

/* design/pic_if.sv */
// Handshake interfaces of the PWM input capture block: item input,
// result output and configuration write. Depends on pic_pkg for widths.

// Input items: edge events and read requests.
interface pic_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [pic_pkg::ChW-1:0]       channel;
  logic                          level;
  logic [pic_pkg::TsW-1:0]       timestamp;

  modport source (output valid, req_type, channel, level, timestamp, input ready);
  modport sink   (input valid, req_type, channel, level, timestamp, output ready);
endinterface

// Result items: one per read request.
interface pic_out_if;
  logic                          valid;
  logic                          ready;
  logic [pic_pkg::ChW-1:0]       out_channel;
  logic [pic_pkg::TsW-1:0]       frequency;
  logic [pic_pkg::DutyW-1:0]     duty_percent;
  logic                          valid_res;

  modport source (output valid, out_channel, frequency, duty_percent, valid_res,
                  input ready);
  modport sink   (input valid, out_channel, frequency, duty_percent, valid_res,
                  output ready);
endinterface

// Configuration writes of the ticks-per-second register.
interface pic_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pic_pkg::TpsW-1:0]      data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/pwm_input_capture_top.sv */
// PWM input capture top level: per-channel stamp storage, sequencer and one
// shared restoring divider. Depends on pic_pkg and the interfaces in pic_if.sv.
//
// Usage: edge beats (req_type 0) are taken while idle and update the
// addressed channel only while it is armed. A read beat (req_type 1) holds the
// input after it is accepted while the sequencer forms period and on time,
// runs 32 divider steps for the frequency, forms on time times 100, runs 39
// divider steps for the duty, and hands the result to the output register.
// The single divider gives one quotient bit per cycle; a read on a channel out
// of range, with no completed cycle or with a zero period skips the divider
// steps. The hand-over to the output register waits while the output
// register still holds an unaccepted result. The input is not ready while a
// read is in work. A finished result waits in the output register, so the
// next beat is taken while it is still pending. The configuration port is
// always ready and must only be written while idle.
module pwm_input_capture_top #(
  parameter int unsigned CHANNELS = pic_pkg::Channels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pic_in_if.sink      in_i,
  pic_out_if.source   res_o,
  pic_cfg_if.sink     cfg_i
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned TsW    = pic_pkg::TsW;
  localparam int unsigned DivW   = pic_pkg::DivW;
  localparam int unsigned CntW   = pic_pkg::DivCntW;
  localparam int unsigned ProdW  = pic_pkg::ProdW;
  localparam int unsigned DutyW  = pic_pkg::DutyW;

  pic_pkg::pic_state_e state_q, state_d;

  // Configuration register.
  logic [pic_pkg::TpsW-1:0] tps_q;

  // Per-channel capture state.
  logic [TsW-1:0]      start_q [CHANNELS];
  logic [TsW-1:0]      prev_q  [CHANNELS];
  logic [TsW-1:0]      stop_q  [CHANNELS];
  logic [CHANNELS-1:0] armed_q;

  // Read request context.
  logic [pic_pkg::ChW-1:0] ch_q;
  logic [ChIdxW-1:0]       idx_q;
  logic                    rng_q;
  logic                    ok_q;
  logic [TsW-1:0]          period_q;
  logic [TsW-1:0]          on_q;
  logic [TsW-1:0]          freq_q;
  logic [DutyW-1:0]        duty_q;

  // Shared divider registers.
  logic [TsW-1:0]  rem_q;
  logic [DivW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;

  // Output register.
  logic                    out_valid_q;
  logic [pic_pkg::ChW-1:0] out_ch_q;
  logic [TsW-1:0]          out_freq_q;
  logic [DutyW-1:0]        out_duty_q;
  logic                    out_vres_q;

  logic              in_acc;
  logic [ChIdxW-1:0] in_idx;
  logic              in_rng;
  logic              slot_free;
  logic              div_last;

  // Handshake terms and channel decode.
  assign in_i.ready  = (state_q == pic_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign in_idx      = ChIdxW'(in_i.channel);
  assign in_rng      = (32'(in_i.channel) < CHANNELS);
  assign slot_free   = !out_valid_q || res_o.ready;
  assign div_last    = (cnt_q == '0);

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  logic [TsW:0]    rem_sh;
  logic [TsW:0]    rem_sub;
  logic            rem_ge;
  logic [TsW-1:0]  rem_d;
  logic [DivW-1:0] quo_d;

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, period_q});
  assign rem_sub = rem_sh - {1'b0, period_q};
  assign rem_d   = rem_ge ? rem_sub[TsW-1:0] : rem_sh[TsW-1:0];
  assign quo_d   = {quo_q[DivW-2:0], rem_ge};

  // Duty quotient saturated at full scale.
  logic [DutyW-1:0] duty_sat;
  assign duty_sat = (quo_d[ProdW-1:0] > ProdW'(pic_pkg::DutyFull)) ?
                    pic_pkg::DutyFull : quo_d[DutyW-1:0];

  // On time times 100 for the duty dividend.
  logic [ProdW-1:0] duty_prod;
  assign duty_prod = ProdW'(on_q) * ProdW'(pic_pkg::DutyFull);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pic_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pic_pkg::S_IDLE: begin
        if (in_acc && in_i.req_type) state_d = pic_pkg::S_CALC;
      end
      pic_pkg::S_CALC: begin
        state_d = pic_pkg::S_DIVF;
      end
      pic_pkg::S_DIVF: begin
        if (!ok_q) state_d = pic_pkg::S_DONE;
        else if (div_last) state_d = pic_pkg::S_LDD;
      end
      pic_pkg::S_LDD: begin
        state_d = pic_pkg::S_DIVD;
      end
      pic_pkg::S_DIVD: begin
        if (div_last) state_d = pic_pkg::S_DONE;
      end
      pic_pkg::S_DONE: begin
        if (slot_free) state_d = pic_pkg::S_IDLE;
      end
      default: begin
        state_d = pic_pkg::S_IDLE;
      end
    endcase
  end

  // Configuration register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= pic_pkg::TpsReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tps_q <= cfg_i.data;
    end
  end

  // Capture stamps and arm flags. Edges land only on armed channels; a read
  // arms its channel once the stamps have been sampled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        start_q[i] <= '0;
        prev_q[i]  <= '0;
        stop_q[i]  <= '0;
      end
    end else begin
      if (in_acc && !in_i.req_type && in_rng && armed_q[in_idx]) begin
        if (in_i.level) begin
          prev_q[in_idx]  <= start_q[in_idx];
          start_q[in_idx] <= in_i.timestamp;
        end else begin
          stop_q[in_idx] <= in_i.timestamp;
        end
      end
      if (state_q == pic_pkg::S_CALC && rng_q) begin
        armed_q[idx_q] <= 1'b1;
      end
    end
  end

  // Read datapath: sample the stamps, then, for a valid measurement, run the shared divider twice.
  always_ff @(posedge clk_i) begin
    case (state_q)
      pic_pkg::S_IDLE: begin
        if (in_acc && in_i.req_type) begin
          ch_q  <= in_i.channel;
          idx_q <= in_idx;
          rng_q <= in_rng;
        end
      end
      pic_pkg::S_CALC: begin
        period_q <= start_q[idx_q] - prev_q[idx_q];
        on_q     <= stop_q[idx_q] - start_q[idx_q];
        ok_q     <= rng_q && (start_q[idx_q] < stop_q[idx_q]) &&
                    (start_q[idx_q] != prev_q[idx_q]);
        rem_q    <= '0;
        quo_q    <= {tps_q, (DivW-TsW)'(0)};
        cnt_q    <= CntW'(pic_pkg::FreqSteps - 1);
      end
      pic_pkg::S_DIVF: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - CntW'(1);
        if (div_last) freq_q <= quo_d[TsW-1:0];
      end
      pic_pkg::S_LDD: begin
        rem_q <= '0;
        quo_q <= {duty_prod, (DivW-ProdW)'(0)};
        cnt_q <= CntW'(pic_pkg::DutySteps - 1);
      end
      pic_pkg::S_DIVD: begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - CntW'(1);
        if (div_last) duty_q <= duty_sat;
      end
      default: begin
      end
    endcase
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == pic_pkg::S_DONE && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload; invalid measurements report zeros.
  always_ff @(posedge clk_i) begin
    if (state_q == pic_pkg::S_DONE && slot_free) begin
      out_ch_q   <= ch_q;
      out_vres_q <= ok_q;
      out_freq_q <= ok_q ? freq_q : '0;
      out_duty_q <= ok_q ? duty_q : '0;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_channel  = out_ch_q;
  assign res_o.frequency    = out_freq_q;
  assign res_o.duty_percent = out_duty_q;
  assign res_o.valid_res    = out_vres_q;

`ifndef SYNTHESIS
  // An accepted read beat always starts the measurement sequence.
  a_read_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.req_type) |=> (state_q == pic_pkg::S_CALC))
    else $error("read beat did not start a measurement");

  // The divider remainder stays below the divisor while dividing.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == pic_pkg::S_DIVD) || (state_q == pic_pkg::S_DIVF && ok_q))
    |-> (rem_q < period_q))
    else $error("divider remainder not below period");

  // Reported duty never exceeds full scale.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_duty_q <= pic_pkg::DutyFull))
    else $error("duty above full scale");

  // An invalid measurement reports zero frequency and duty.
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_vres_q) |-> (out_freq_q == '0 && out_duty_q == '0))
    else $error("invalid result carries nonzero data");

  // Once armed, channel 0 stays armed.
  a_armed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q[0] |=> armed_q[0])
    else $error("armed flag cleared");
`endif

endmodule
